/* sv/uart_register_capture_macros.svh */
// ----------------------------------------------------------------------------
// UART register capture assertion macros
// Shared concurrent assertion forms for the capture block checker.
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_CAPTURE_MACROS_SVH
`define UART_REGISTER_CAPTURE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge
`define URC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge
`define URC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/urc_pkg.sv */
// ----------------------------------------------------------------------------
// urc_pkg
// Types and constants of the UART register capture block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urc_pkg;

   // capture buffer geometry
   localparam int CAPTURE_DEPTH = 32;
   localparam int ADDR_W        = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
   localparam int COUNT_W       = 6;

   // register emulation constants
   localparam logic [7:0] LINE_STATUS_VALUE = 8'h60;
   localparam int         DLAB_BIT          = 7;

   // register offsets
   localparam logic [2:0] OFS_DIVISOR_LOW  = 3'd0;
   localparam logic [2:0] OFS_DIVISOR_HIGH = 3'd1;
   localparam logic [2:0] OFS_LINE_CONTROL = 3'd3;
   localparam logic [2:0] OFS_LINE_STATUS  = 3'd5;

   // request commands
   typedef enum logic [1:0] {
      CMD_PORT_READ  = 2'd0,
      CMD_PORT_WRITE = 2'd1,
      CMD_PUT_BYTE   = 2'd2,
      CMD_DUMP       = 2'd3
   } command_type;

endpackage

/* sv/uart_register_capture.sv */
// ----------------------------------------------------------------------------
// uart_register_capture
// 16550-style register front end that captures transmitted bytes in a
// buffer memory and streams them out on a dump command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | command, reg_offset, write_data
//  rsp     | out       | rsp_valid / rsp_ready | read_data, captured_byte,
//          |           |                       | byte_valid, dump_count, last
//  csr     | in        | csr_valid / csr_ready | emulation_enabled
//
//  Port reads, port writes and byte puts each give one result; back-to-back
//  transactions run at one per cycle while rsp_ready stays high. A dump of
//  stored bytes primes the read register with one buffer memory read, then
//  gives one result per stored byte and ends with the count result. A dump
//  of an empty buffer answers with the count result alone.
//  Reset is synchronous; no clearing pass is needed, the fill level gates
//  every buffer read. Stalls on rsp hold the output register and pause the
//  dump walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_register_capture
   import urc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_reg_offset,
   input  logic [7:0]         req_write_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data,
   output logic [7:0]         rsp_captured_byte,
   output logic               rsp_byte_valid,
   output logic [COUNT_W-1:0] rsp_dump_count,
   output logic               rsp_last,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_emulation_enabled
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUMP,
      ST_FINAL
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_read_data_ff;
   logic [7:0]         rsp_captured_byte_ff;
   logic               rsp_byte_valid_ff;
   logic [COUNT_W-1:0] rsp_dump_count_ff;
   logic               rsp_last_ff;

   logic               enabled_ff;
   logic [7:0]         divisor_low_ff;
   logic [7:0]         divisor_high_ff;
   logic [7:0]         line_control_ff;
   logic [COUNT_W-1:0] fill_ff;
   logic [COUNT_W-1:0] dump_cnt_ff;
   logic [ADDR_W-1:0]  idx_ff;

   // capture buffer memory
   logic [7:0]         capture_mem [CAPTURE_DEPTH];
   logic [7:0]         rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr_in;

   command_type        cmd;
   logic               slot_free;
   logic               req_fire;
   logic               dlab;
   logic               append_en;
   logic               is_last_byte;
   logic [7:0]         port_rdata;

   assign cmd          = command_type'(req_command);
   assign dlab         = line_control_ff[DLAB_BIT];
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE) && slot_free;
   assign req_fire     = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign is_last_byte = (COUNT_W'(idx_ff) + COUNT_W'(1)) == dump_cnt_ff;

   // byte append while the buffer has room: direct put, or data register write outside DLAB with emulation on
   assign append_en = req_fire && (fill_ff < COUNT_W'(CAPTURE_DEPTH)) &&
                      ((cmd == CMD_PUT_BYTE) ||
                       ((cmd == CMD_PORT_WRITE) && enabled_ff && !dlab &&
                        (req_reg_offset == OFS_DIVISOR_LOW)));

   // register read mux
   always_comb begin
      unique case (req_reg_offset)
         OFS_DIVISOR_LOW:  port_rdata = dlab ? divisor_low_ff : 8'h00;
         OFS_DIVISOR_HIGH: port_rdata = dlab ? divisor_high_ff : 8'h00;
         OFS_LINE_CONTROL: port_rdata = line_control_ff;
         OFS_LINE_STATUS:  port_rdata = LINE_STATUS_VALUE;
         default:          port_rdata = 8'h00;
      endcase
   end

   // read address: advance only when the current byte moves to the output
   always_comb begin
      if ((state_ff == ST_DUMP) && slot_free && !is_last_byte) begin
         rd_addr_in = idx_ff + ADDR_W'(1);
      end else if (state_ff == ST_DUMP) begin
         rd_addr_in = idx_ff;
      end else begin
         rd_addr_in = '0;
      end
   end

   // buffer memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (append_en) begin
         capture_mem[fill_ff[ADDR_W-1:0]] <= req_write_data;
      end
      rd_data_ff <= capture_mem[rd_addr_in];
   end

   // control, register file and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         enabled_ff      <= 1'b1;
         divisor_low_ff  <= 8'h00;
         divisor_high_ff <= 8'h00;
         line_control_ff <= 8'h00;
         fill_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            enabled_ff <= csr_emulation_enabled;
         end
         if (append_en) begin
            fill_ff <= fill_ff + COUNT_W'(1);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  // single result with last set; a non-empty dump walks the
                  // buffer first, entry 0 is read this cycle
                  rsp_valid_ff         <= (cmd != CMD_DUMP) || (fill_ff == '0);
                  rsp_read_data_ff     <= ((cmd == CMD_PORT_READ) && enabled_ff) ?
                                          port_rdata : 8'h00;
                  rsp_captured_byte_ff <= 8'h00;
                  rsp_byte_valid_ff    <= 1'b0;
                  rsp_dump_count_ff    <= '0;
                  rsp_last_ff          <= 1'b1;
                  unique case (cmd)
                     CMD_PORT_READ: begin
                        // read data selected above
                     end
                     CMD_PORT_WRITE: begin
                        if (enabled_ff) begin
                           if (req_reg_offset == OFS_DIVISOR_LOW && dlab) begin
                              divisor_low_ff <= req_write_data;
                           end
                           if (req_reg_offset == OFS_DIVISOR_HIGH && dlab) begin
                              divisor_high_ff <= req_write_data;
                           end
                           if (req_reg_offset == OFS_LINE_CONTROL) begin
                              line_control_ff <= req_write_data;
                           end
                        end
                     end
                     CMD_PUT_BYTE: begin
                        // handled by the append path
                     end
                     CMD_DUMP: begin
                        fill_ff <= '0;
                        if (fill_ff != '0) begin
                           dump_cnt_ff <= fill_ff;
                           idx_ff      <= '0;
                           state_ff    <= ST_DUMP;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_DUMP: begin
               if (slot_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_read_data_ff     <= 8'h00;
                  rsp_captured_byte_ff <= rd_data_ff;
                  rsp_byte_valid_ff    <= 1'b1;
                  rsp_dump_count_ff    <= '0;
                  rsp_last_ff          <= 1'b0;
                  idx_ff               <= idx_ff + ADDR_W'(1);
                  if (is_last_byte) begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               if (slot_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_read_data_ff     <= 8'h00;
                  rsp_captured_byte_ff <= 8'h00;
                  rsp_byte_valid_ff    <= 1'b0;
                  rsp_dump_count_ff    <= dump_cnt_ff;
                  rsp_last_ff          <= 1'b1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_captured_byte = rsp_captured_byte_ff;
   assign rsp_byte_valid    = rsp_byte_valid_ff;
   assign rsp_dump_count    = rsp_dump_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* sv/urc_checker.sv */
// ----------------------------------------------------------------------------
// urc_checker
// Port-level checks of the UART register capture block, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_register_capture_macros.svh"

module urc_checker
   import urc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_command,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [7:0]         rsp_read_data,
   input logic [7:0]         rsp_captured_byte,
   input logic               rsp_byte_valid,
   input logic [COUNT_W-1:0] rsp_dump_count,
   input logic               rsp_last
);

   logic                rsp_stall;
   logic [COUNT_W+17:0] rsp_data;
   logic                byte_clean;
   logic                req_take;
   logic                single_cmd;
   logic                single_done;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_data    = {rsp_read_data, rsp_captured_byte, rsp_byte_valid,
                         rsp_dump_count, rsp_last};
   assign byte_clean  = !rsp_last && (rsp_read_data == 8'h00) && (rsp_dump_count == '0);
   assign req_take    = req_valid && req_ready;
   assign single_cmd  = command_type'(req_command) != CMD_DUMP;
   assign single_done = rsp_valid && rsp_last && !rsp_byte_valid;

   // a stalled response keeps its payload
   `URC_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data), "stall broken")

   // a dumped byte result carries nothing else
   `URC_ASSERT_NOW(a_byte, clock, reset, rsp_valid && rsp_byte_valid, byte_clean, "stray dump fields")

   // while a dumped byte waits the walk is still running, so no request
   `URC_ASSERT_NOW(a_busy, clock, reset, rsp_valid && rsp_byte_valid, !req_ready, "request mid-dump")

   // a single-result command answers in the next cycle with last set
   `URC_ASSERT_NEXT(a_single, clock, reset, req_take && single_cmd, single_done, "no single result")

endmodule

bind uart_register_capture urc_checker u_urc_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UART register capture block. A queue-fed
// driver offers bus transactions in random bursts, a monitor predicts the
// register, capture buffer and dump behavior of every accepted transaction
// and checks each response field against the oldest expected one. The
// emulation enable is switched between traffic phases while the block is
// idle, and the receiver stalls at random and once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import urc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 8;
   localparam int LONG_HOLD    = 400;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      command_type cmd;
      logic [2:0]  ofs;
      logic [7:0]  data;
   } bus_txn;

   typedef struct packed {
      logic [7:0]         read_data;
      logic [7:0]         captured_byte;
      logic               byte_valid;
      logic [COUNT_W-1:0] dump_count;
      logic               last;
   } rsp_txn;

   // DUT connections
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_command;
   logic [2:0]         req_reg_offset;
   logic [7:0]         req_write_data;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_read_data;
   logic [7:0]         rsp_captured_byte;
   logic               rsp_byte_valid;
   logic [COUNT_W-1:0] rsp_dump_count;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_emulation_enabled;

   // stimulus and scoreboard state
   bus_txn pending_txns[$];
   rsp_txn expected_rsps[$];
   int     n_issued;
   int     n_accepted;
   int     error_count;
   int     cycle_count;
   logic   req_taken;
   logic   sender_gaps;
   int     burst_left;
   int     gap_left;
   int     hold_token;
   int     hold_seen;
   int     hold_left;
   int     stall_mode;
   int     mode_left;

   // mirror of the block state
   logic               emul_on;
   logic [7:0]         div_low;
   logic [7:0]         div_high;
   logic [7:0]         line_ctrl;
   logic [7:0]         capture_mem[CAPTURE_DEPTH];
   logic [COUNT_W-1:0] fill;

   uart_register_capture u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_reg_offset        (req_reg_offset),
      .req_write_data        (req_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_captured_byte     (rsp_captured_byte),
      .rsp_byte_valid        (rsp_byte_valid),
      .rsp_dump_count        (rsp_dump_count),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_emulation_enabled (csr_emulation_enabled)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void capture_byte(input logic [7:0] b);
      if (fill < CAPTURE_DEPTH) begin
         capture_mem[fill] = b;
         fill = fill + 1'b1;
      end
   endfunction

   function automatic void predict_capture(input bus_txn t);
      rsp_txn r;
      logic   dlab;
      r      = '0;
      r.last = 1'b1;
      dlab   = line_ctrl[DLAB_BIT];
      case (t.cmd)
         CMD_PORT_READ: begin
            if (emul_on) begin
               case (t.ofs)
                  OFS_DIVISOR_LOW:  r.read_data = dlab ? div_low : 8'h00;
                  OFS_DIVISOR_HIGH: r.read_data = dlab ? div_high : 8'h00;
                  OFS_LINE_CONTROL: r.read_data = line_ctrl;
                  OFS_LINE_STATUS:  r.read_data = LINE_STATUS_VALUE;
                  default:          r.read_data = 8'h00;
               endcase
            end
            expected_rsps.push_back(r);
         end
         CMD_PORT_WRITE: begin
            if (emul_on) begin
               case (t.ofs)
                  OFS_DIVISOR_LOW: begin
                     if (dlab) div_low = t.data;
                     else capture_byte(t.data);
                  end
                  OFS_DIVISOR_HIGH: begin
                     if (dlab) div_high = t.data;
                  end
                  OFS_LINE_CONTROL: line_ctrl = t.data;
                  default: ;
               endcase
            end
            expected_rsps.push_back(r);
         end
         CMD_PUT_BYTE: begin
            capture_byte(t.data);
            expected_rsps.push_back(r);
         end
         default: begin
            // dump: one byte per entry, then the count
            for (int i = 0; i < fill; i++) begin
               r               = '0;
               r.captured_byte = capture_mem[i];
               r.byte_valid    = 1'b1;
               expected_rsps.push_back(r);
            end
            r            = '0;
            r.dump_count = fill;
            r.last       = 1'b1;
            expected_rsps.push_back(r);
            fill = '0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request driver: bursts with random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      bus_txn t;
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_txns.size() > 0) begin
            t = pending_txns.pop_front();
            n_issued++;
            req_valid      <= 1'b1;
            req_command    <= t.cmd;
            req_reg_offset <= t.ofs;
            req_write_data <= t.data;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = sender_gaps ? $urandom_range(1, 8) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response ready: stall modes plus an on-demand long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // monitor: check responses, then predict accepted requests
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_txn got;
      rsp_txn want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_read_data, rsp_captured_byte, rsp_byte_valid,
                    rsp_dump_count, rsp_last};
            if (expected_rsps.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected response rd=%h cb=%h bv=%b cnt=%0d last=%b",
                           $time, got.read_data, got.captured_byte, got.byte_valid,
                           got.dump_count, got.last);
            end else begin
               want = expected_rsps.pop_front();
               if (got.read_data !== want.read_data
                   || got.captured_byte !== want.captured_byte
                   || got.byte_valid !== want.byte_valid
                   || got.dump_count !== want.dump_count
                   || got.last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("%0t: mismatch exp rd=%h cb=%h bv=%b cnt=%0d last=%b, got rd=%h cb=%h bv=%b cnt=%0d last=%b",
                              $time, want.read_data, want.captured_byte, want.byte_valid,
                              want.dump_count, want.last, got.read_data, got.captured_byte,
                              got.byte_valid, got.dump_count, got.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            n_accepted++;
            predict_capture('{command_type'(req_command), req_reg_offset, req_write_data});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void push_txn(input command_type c, input logic [2:0] o,
                                    input logic [7:0] d);
      pending_txns.push_back('{c, o, d});
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] rand_ofs();
      return 3'($urandom_range(0, 7));
   endfunction

   // random traffic, mostly structured capture and register sequences
   function automatic void queue_traffic(input int n_txns);
      int start;
      int kind;
      int len;
      start = pending_txns.size();
      while (pending_txns.size() - start < n_txns) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            // capture run: optional DLAB clear, bytes, then a dump
            if ($urandom_range(0, 1))
               push_txn(CMD_PORT_WRITE, OFS_LINE_CONTROL, {1'b0, 7'($urandom_range(0, 127))});
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
            repeat (len) begin
               if ($urandom_range(0, 1)) push_txn(CMD_PUT_BYTE, rand_ofs(), rand_byte());
               else push_txn(CMD_PORT_WRITE, OFS_DIVISOR_LOW, rand_byte());
            end
            push_txn(CMD_DUMP, rand_ofs(), rand_byte());
         end else if (kind <= 6) begin
            // register run: set DLAB, poke and peek random offsets
            push_txn(CMD_PORT_WRITE, OFS_LINE_CONTROL, {1'b1, 7'($urandom_range(0, 127))});
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 1)) push_txn(CMD_PORT_WRITE, rand_ofs(), rand_byte());
               else push_txn(CMD_PORT_READ, rand_ofs(), rand_byte());
            end
            push_txn(CMD_PORT_WRITE, OFS_LINE_CONTROL, rand_byte());
            push_txn(CMD_PORT_READ, rand_ofs(), rand_byte());
         end else if (kind <= 8) begin
            // noise
            repeat ($urandom_range(1, 8))
               push_txn(command_type'($urandom_range(0, 3)), rand_ofs(), rand_byte());
         end else begin
            push_txn(CMD_DUMP, rand_ofs(), rand_byte());
         end
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_txns.size() != 0 || n_issued != n_accepted || expected_rsps.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_emulation(input logic en);
      @(negedge clock);
      csr_valid             <= 1'b1;
      csr_emulation_enabled <= en;
      do @(posedge clock);
      while (!csr_ready);
      emul_on = en;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_command           = CMD_PORT_READ;
      req_reg_offset        = '0;
      req_write_data        = '0;
      rsp_ready             = 1'b0;
      csr_valid             = 1'b0;
      csr_emulation_enabled = 1'b1;
      n_issued              = 0;
      n_accepted            = 0;
      error_count           = 0;
      cycle_count           = 0;
      sender_gaps           = 1'b0;
      burst_left            = 0;
      gap_left              = 0;
      hold_token            = 0;
      hold_seen             = 0;
      hold_left             = 0;
      stall_mode            = 0;
      mode_left             = 0;
      emul_on               = 1'b1;
      div_low               = '0;
      div_high              = '0;
      line_ctrl             = '0;
      fill                  = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // emulation on, back-to-back directed transactions
      write_emulation(1'b1);
      push_txn(CMD_PORT_READ, OFS_LINE_STATUS, 8'h00);
      push_txn(CMD_PORT_READ, OFS_DIVISOR_LOW, 8'hFF);
      push_txn(CMD_PORT_READ, OFS_LINE_CONTROL, 8'h00);
      push_txn(CMD_PORT_READ, 3'd7, 8'h00);
      push_txn(CMD_PORT_WRITE, OFS_LINE_CONTROL, 8'h80);
      push_txn(CMD_PORT_WRITE, OFS_DIVISOR_LOW, 8'hFF);
      push_txn(CMD_PORT_WRITE, OFS_DIVISOR_HIGH, 8'h00);
      push_txn(CMD_PORT_READ, OFS_DIVISOR_LOW, 8'h00);
      push_txn(CMD_PORT_READ, OFS_DIVISOR_HIGH, 8'h00);
      push_txn(CMD_PORT_WRITE, OFS_LINE_CONTROL, 8'h7F);
      push_txn(CMD_PORT_READ, OFS_LINE_CONTROL, 8'h00);
      push_txn(CMD_PORT_READ, OFS_DIVISOR_LOW, 8'h00);
      push_txn(CMD_PORT_WRITE, OFS_DIVISOR_LOW, 8'hA5);
      push_txn(CMD_PORT_WRITE, OFS_DIVISOR_HIGH, 8'h5A);
      push_txn(CMD_PORT_WRITE, 3'd2, 8'hFF);
      push_txn(CMD_PORT_WRITE, OFS_LINE_STATUS, 8'h00);
      push_txn(CMD_PORT_WRITE, 3'd7, 8'hFF);
      push_txn(CMD_PUT_BYTE, 3'd7, 8'h00);
      push_txn(CMD_PUT_BYTE, 3'd0, 8'hFF);
      push_txn(CMD_DUMP, 3'd0, 8'h00);
      push_txn(CMD_DUMP, 3'd7, 8'hFF);
      wait_idle();

      // overflow the capture buffer, then random traffic with gaps
      sender_gaps = 1'b1;
      repeat (CAPTURE_DEPTH + 3) push_txn(CMD_PUT_BYTE, rand_ofs(), rand_byte());
      push_txn(CMD_DUMP, rand_ofs(), rand_byte());
      queue_traffic(130);
      wait_idle();

      // emulation off: port accesses inert, puts and dumps still work
      write_emulation(1'b0);
      queue_traffic(100);
      wait_idle();

      // emulation back on; long receiver hold-off while requests keep coming
      write_emulation(1'b1);
      @(posedge clock);
      hold_token++;
      queue_traffic(80);
      wait_idle();
      sender_gaps = 1'b0;
      queue_traffic(60);
      wait_idle();

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/urc_pkg.sv
sv/uart_register_capture.sv
sv/urc_checker.sv
tb/tb_top.sv
